[sv/dts_pkg.sv]
package dts_pkg;

   localparam int MAX_DELIMS  = 8;
   localparam int OFFSET_BITS = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic CSR_DELIM_BYTES = 1'b0;
   localparam logic CSR_DELIM_COUNT = 1'b1;

   typedef logic [OFFSET_BITS-1:0] off_type;

   localparam off_type OFF_MAX = {OFFSET_BITS{1'b1}};

   typedef struct packed {
      logic [7:0] text_byte;
      logic       row_last;
   } req_payload_type;

   typedef struct packed {
      logic        token_valid;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic        row_done;
      logic [31:0] row_number;
      logic        offset_overflow;
   } rsp_payload_type;

   // Classified byte as it travels from the front to the back.
   typedef struct packed {
      logic is_zero;
      logic keep;
      logic brk;
      logic row_last;
   } cls_type;

   function automatic logic [15:0] to_out16(off_type v);
      logic [OFFSET_BITS+15:0] ext;
      ext = {16'b0, v};
      return ext[15:0];
   endfunction

endpackage

[sv/dts_front.sv]
module dts_front import dts_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write,
   input  logic            csr_index,
   input  logic [63:0]     csr_wdata,
   input  req_payload_type req_payload,
   output cls_type         cls
);

   logic [63:0] delim_ff;
   logic [3:0]  count_ff;
   logic [3:0]  count_sat;
   logic [7:0]  b;
   logic        is_delim;
   logic        is_space;
   logic        is_alnum;
   logic        word_mode;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= '0;
         count_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DELIM_BYTES: delim_ff <= csr_wdata;
            CSR_DELIM_COUNT: count_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      b         = req_payload.text_byte;
      count_sat = (count_ff > 4'(MAX_DELIMS)) ? 4'(MAX_DELIMS) : count_ff;
      word_mode = (count_ff == 4'd0);
      is_space  = (b == 8'd32) || (b inside {[8'd9:8'd13]});
      is_alnum  = (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
      is_delim  = 1'b0;
      for (int k = 0; k < MAX_DELIMS; k++) begin
         if ((4'(k) < count_sat) && (delim_ff[8*k +: 8] == b)) begin
            is_delim = 1'b1;
         end
      end
      // Without delimiters a token is a run of letters and digits; with them,
      // a token is broken only by a delimiter and whitespace is not kept.
      cls.is_zero  = (b == 8'd0);
      cls.keep     = word_mode ? is_alnum : (!is_delim && !is_space);
      cls.brk      = word_mode ? !is_alnum : is_delim;
      cls.row_last = req_payload.row_last;
   end

endmodule

[sv/dts_queue.sv]
module dts_queue import dts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_item,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cls_type pop_item
);

   cls_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW:0]   fill_ff;
   logic [QUEUE_AW:0]   fill_in;

   assign full      = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[sv/dts_back.sv]
module dts_back import dts_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  cls_type         q_item,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            inside_ff, inside_in;
   off_type         start_ff, start_in;
   off_type         kept_ff, kept_in;
   off_type         pos_ff, pos_in;
   logic            ended_ff, ended_in;
   logic [31:0]     row_ff, row_in;
   logic            sat_ff, sat_in;
   logic            top_ff, top_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;
   logic            emit;
   logic            produce;
   off_type         off;
   logic [OFFSET_BITS:0] len_w;
   off_type         len;

   assign q_pop       = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      inside_in = inside_ff;
      start_in  = start_ff;
      kept_in   = kept_ff;
      pos_in    = pos_ff;
      ended_in  = ended_ff;
      row_in    = row_ff;
      sat_in    = sat_ff;
      top_in    = top_ff;
      emit      = 1'b0;
      off       = pos_ff;

      if (!ended_ff) begin
         if (q_item.is_zero) begin
            ended_in = 1'b1;
            emit     = inside_ff;
         end else begin
            // Once a byte has taken the top offset, every later byte saturates.
            if (top_ff) begin
               sat_in = 1'b1;
            end
            if (pos_ff == OFF_MAX) begin
               top_in = 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
            if (inside_ff) begin
               if (q_item.brk) begin
                  emit = 1'b1;
               end else if (q_item.keep) begin
                  kept_in = off;
               end
            end else if (q_item.keep) begin
               inside_in = 1'b1;
               start_in  = off;
               kept_in   = off;
            end
         end
      end
      if (q_item.row_last && inside_in) begin
         emit = 1'b1;
      end
      produce = emit || q_item.row_last;

      len_w = {1'b0, kept_in} - {1'b0, start_in} + 1'b1;
      len   = len_w[OFFSET_BITS] ? OFF_MAX : len_w[OFFSET_BITS-1:0];

      rsp_in.token_valid     = emit;
      rsp_in.token_start     = emit ? to_out16(start_in) : 16'd0;
      rsp_in.token_length    = emit ? to_out16(len) : 16'd0;
      rsp_in.row_done        = q_item.row_last;
      rsp_in.row_number      = row_ff;
      rsp_in.offset_overflow = sat_in;

      if (emit) begin
         inside_in = 1'b0;
      end
      if (q_item.row_last) begin
         inside_in = 1'b0;
         start_in  = '0;
         kept_in   = '0;
         pos_in    = '0;
         ended_in  = 1'b0;
         sat_in    = 1'b0;
         top_in    = 1'b0;
         row_in    = row_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         start_ff     <= '0;
         kept_ff      <= '0;
         pos_ff       <= '0;
         ended_ff     <= 1'b0;
         row_ff       <= '0;
         sat_ff       <= 1'b0;
         top_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            inside_ff <= inside_in;
            start_ff  <= start_in;
            kept_ff   <= kept_in;
            pos_ff    <= pos_in;
            ended_ff  <= ended_in;
            row_ff    <= row_in;
            sat_ff    <= sat_in;
            top_ff    <= top_in;
         end
         if (q_pop && produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && produce) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[sv/delimiter_token_splitter.sv]
// A byte accepted on req is written into the queue; the back end pops it into the rsp register
// once that register is free, and beats queued ahead of it and rsp stalls delay the result.
// Throughput: one byte per cycle; req stalls only while the four-entry queue is full. Reset
// (synchronous) clears the delimiter registers, the queue, the row state and the row counter.
module delimiter_token_splitter import dts_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write,
   input  logic            csr_index,
   input  logic [63:0]     csr_wdata
);

   cls_type cls;
   cls_type q_item;
   logic    q_full;
   logic    q_valid;
   logic    q_pop;
   logic    push;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   dts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .cls         (cls)
   );

   dts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (cls),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_item  (q_item)
   );

   dts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[tb/token_result_checker.sv]
module token_result_checker import dts_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_write,
   input  logic            csr_index,
   input  logic [63:0]     csr_wdata,
   output int              fail_count,
   output int              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 50;

   logic [63:0]     delim_bytes;
   logic [3:0]      delim_count;
   logic            in_token;
   off_type         tok_start;
   off_type         tok_end;
   off_type         next_pos;
   logic            content_over;
   logic            row_saturated;
   logic            top_taken;
   logic [31:0]     row_idx;
   rsp_payload_type expected_tokens[$];
   int              errors = 0;

   assign fail_count = errors;

   task automatic flag_mismatch(input string what);
      errors++;
      if (errors <= PRINT_CAP) begin
         $display("%0t: token check: %s", $time, what);
      end
   endtask

   task automatic clear_row_state();
      in_token      = 1'b0;
      tok_start     = '0;
      tok_end       = '0;
      next_pos      = '0;
      content_over  = 1'b0;
      row_saturated = 1'b0;
      top_taken     = 1'b0;
   endtask

   // Works out the result, if any, that one accepted text beat causes.
   task automatic predict_token_result(input req_payload_type beat);
      logic [7:0]           ch;
      logic                 row_end;
      logic [3:0]           n;
      logic                 close_tok;
      logic                 is_delim;
      logic                 is_space;
      logic                 is_alnum;
      off_type              here;
      logic [OFFSET_BITS:0] span;
      rsp_payload_type      want;
      ch        = beat.text_byte;
      row_end   = beat.row_last;
      n         = (delim_count > MAX_DELIMS) ? 4'(MAX_DELIMS) : delim_count;
      close_tok = 1'b0;
      if (!content_over) begin
         if (ch == 8'h00) begin
            content_over = 1'b1;
            if (in_token) close_tok = 1'b1;
         end else begin
            // Once the top offset is taken, every further byte marks the row saturated.
            if (top_taken) row_saturated = 1'b1;
            here = next_pos;
            if (next_pos == OFF_MAX) top_taken = 1'b1;
            else next_pos = next_pos + 1'b1;
            is_alnum = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
                       (ch >= 8'h61 && ch <= 8'h7A);
            is_space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
            is_delim = 1'b0;
            for (int k = 0; k < n; k++) begin
               if (delim_bytes[8*k +: 8] == ch) is_delim = 1'b1;
            end
            if (n == 0) begin
               if (is_alnum) begin
                  if (!in_token) begin
                     in_token  = 1'b1;
                     tok_start = here;
                  end
                  tok_end = here;
               end else if (in_token) begin
                  close_tok = 1'b1;
               end
            end else if (in_token) begin
               if (is_delim) close_tok = 1'b1;
               else if (!is_space) tok_end = here;
            end else if (!is_delim && !is_space) begin
               in_token  = 1'b1;
               tok_start = here;
               tok_end   = here;
            end
         end
      end
      if (row_end && in_token) close_tok = 1'b1;
      if (close_tok || row_end) begin
         want = '0;
         if (close_tok) begin
            span = {1'b0, tok_end} - {1'b0, tok_start} + 1'b1;
            if (span > {1'b0, OFF_MAX}) span = {1'b0, OFF_MAX};
            want.token_valid  = 1'b1;
            want.token_start  = 16'(tok_start);
            want.token_length = 16'(span);
            in_token          = 1'b0;
         end
         want.row_done        = row_end;
         want.row_number      = row_idx;
         want.offset_overflow = row_saturated;
         expected_tokens.insert(expected_tokens.size(), want);
      end
      if (row_end) begin
         clear_row_state();
         row_idx = row_idx + 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         delim_bytes = '0;
         delim_count = '0;
         row_idx     = '0;
         clear_row_state();
         expected_tokens.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DELIM_BYTES: begin
                  delim_bytes = csr_wdata;
               end
               CSR_DELIM_COUNT: begin
                  delim_count = csr_wdata[3:0];
               end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               flag_mismatch($sformatf("unexpected result: valid %b start %0d len %0d row %0d",
                  rsp_payload.token_valid, rsp_payload.token_start,
                  rsp_payload.token_length, rsp_payload.row_number));
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_payload.token_valid !== want.token_valid)
                  flag_mismatch($sformatf("row %0d token_valid %b, expected %b",
                     want.row_number, rsp_payload.token_valid, want.token_valid));
               if (rsp_payload.token_start !== want.token_start)
                  flag_mismatch($sformatf("row %0d token_start %0d, expected %0d",
                     want.row_number, rsp_payload.token_start, want.token_start));
               if (rsp_payload.token_length !== want.token_length)
                  flag_mismatch($sformatf("row %0d token_length %0d, expected %0d",
                     want.row_number, rsp_payload.token_length, want.token_length));
               if (rsp_payload.row_done !== want.row_done)
                  flag_mismatch($sformatf("row %0d row_done %b, expected %b",
                     want.row_number, rsp_payload.row_done, want.row_done));
               if (rsp_payload.row_number !== want.row_number)
                  flag_mismatch($sformatf("row_number %0d, expected %0d",
                     rsp_payload.row_number, want.row_number));
               if (rsp_payload.offset_overflow !== want.offset_overflow)
                  flag_mismatch($sformatf("row %0d offset_overflow %b, expected %b",
                     want.row_number, rsp_payload.offset_overflow, want.offset_overflow));
            end
         end
         if (req_valid && !req_stall) begin
            predict_token_result(req_payload);
         end
      end
      outstanding <= expected_tokens.size();
   end

endmodule

[tb/tb_delimiter_token_splitter.sv]
module tb_delimiter_token_splitter import dts_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] text_row_type[$];

   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 60;
   localparam int RANDOM_BEATS  = 100;

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   req_payload_type req_payload = '0;
   logic            rsp_stall   = 1'b0;
   logic            csr_write   = 1'b0;
   logic            csr_index   = CSR_DELIM_BYTES;
   logic [63:0]     csr_wdata   = '0;
   logic            req_stall;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;
   int              fail_count;
   int              outstanding;

   bit              quiet        = 1'b0;
   bit              hold_request = 1'b0;
   logic [63:0]     cur_delims   = '0;
   int              cur_count    = 0;

   delimiter_token_splitter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   token_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_delimiter_token_splitter: FAIL");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 8);
         end
      end
   end

   task automatic send_beat(input logic [7:0] ch, input logic row_end);
      if (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_payload.text_byte <= ch;
      req_payload.row_last  <= row_end;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering beats until every expected token has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [63:0] delims, input logic [63:0] count_word);
      csr_write <= 1'b1;
      csr_index <= CSR_DELIM_BYTES;
      csr_wdata <= delims;
      @(posedge clock);
      csr_index <= CSR_DELIM_COUNT;
      csr_wdata <= count_word;
      @(posedge clock);
      csr_write  <= 1'b0;
      cur_delims = delims;
      cur_count  = (count_word[3:0] > MAX_DELIMS) ? MAX_DELIMS : int'(count_word[3:0]);
   endtask

   function automatic logic [7:0] rand_alnum();
      int k;
      k = $urandom_range(61);
      if (k < 10) return 8'h30 + 8'(k);
      if (k < 36) return 8'h41 + 8'(k - 10);
      return 8'h61 + 8'(k - 36);
   endfunction

   // Word characters most often, with whitespace, live delimiters, random bytes and the odd zero byte.
   function automatic logic [7:0] rand_text();
      int pick;
      int k;
      pick = $urandom_range(99);
      if (pick < 45) return rand_alnum();
      if (pick < 60) begin
         k = $urandom_range(9, 14);
         return (k == 14) ? 8'h20 : 8'(k);
      end
      if (pick < 78 && cur_count != 0) begin
         k = $urandom_range(cur_count - 1);
         return cur_delims[8*k +: 8];
      end
      if (pick < 82) return 8'h00;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_row(input text_row_type row);
      foreach (row[i]) send_beat(row[i], i == row.size() - 1);
   endtask

   task automatic send_rows(input int beats, input int hold_at);
      int         sent;
      int         len;
      bit         noisy;
      logic [7:0] ch;
      sent = 0;
      while (sent < beats) begin
         len   = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
         noisy = ($urandom_range(9) == 0);
         for (int i = 0; i < len; i++) begin
            ch = noisy ? 8'($urandom_range(255)) : rand_text();
            if (sent == hold_at) hold_request = 1'b1;
            send_beat(ch, i == len - 1);
            sent++;
         end
      end
   endtask

   initial begin
      logic [63:0] delims;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Letter-and-digit mode: class boundaries, a high byte, a token closed by a zero byte.
      set_config(64'h0, 64'h0);
      send_row('{8'h41, 8'h40, 8'h7A, 8'h7B, 8'h30, 8'h3A, 8'h80, 8'h39, 8'h21});
      send_row('{8'h00});
      send_row('{8'h62, 8'h00, 8'h63});
      drain();

      // Delimiters with a zero entry and 0xFF; leading and trailing whitespace.
      set_config(64'h0000_0000_FF00_3B2C, 64'h4);
      send_row('{8'h20, 8'h09, 8'h61, 8'h20, 8'h62, 8'h2C, 8'hFF, 8'h63, 8'h20});
      drain();

      // A count above the maximum saturates, so the eighth byte still acts.
      set_config(64'h2E00_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_row('{8'h61, 8'h2E, 8'h62});
      drain();

      set_config({$urandom, $urandom}, 64'h0);
      send_rows(RANDOM_BEATS, 30);
      drain();

      delims      = {$urandom, $urandom};
      delims[7:0] = 8'h2C;
      set_config(delims, 64'h1);
      send_rows(RANDOM_BEATS, -1);
      drain();

      quiet = 1'b1;
      set_config({$urandom, $urandom}, 64'h8);
      send_rows(RANDOM_BEATS, -1);
      drain();
      quiet = 1'b0;

      delims       = {$urandom, $urandom};
      delims[15:8] = 8'h00;
      set_config(delims, 64'h4);
      send_rows(RANDOM_BEATS, -1);
      drain();

      set_config({$urandom, $urandom}, {$urandom, 28'($urandom), 4'hF});
      send_rows(RANDOM_BEATS, -1);
      drain();

      if (fail_count == 0) begin
         $display("tb_delimiter_token_splitter: PASS");
      end else begin
         $display("tb_delimiter_token_splitter: FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
sv/dts_pkg.sv
sv/dts_front.sv
sv/dts_queue.sv
sv/dts_back.sv
sv/delimiter_token_splitter.sv
tb/token_result_checker.sv
tb/tb_delimiter_token_splitter.sv
